@@ hdl/assert_macros.svh @@
// assertion macros shared by the compensation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies property c in the same cycle
`define BPTC_ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);

// expression must never be true
`define BPTC_ASSERT_NEVER(label, clk, rst_n, e, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(e)) \
    else $error(msg);

`endif

@@ hdl/bptc_pkg.sv @@
// types and constants of the barometric compensation pipeline
package bptc_pkg;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CAL_AC1_AC2 = 3'd0,
    CAL_AC3_AC4 = 3'd1,
    CAL_AC5_AC6 = 3'd2,
    CAL_B1_B2   = 3'd3,
    CAL_MC_MD   = 3'd4
  } cal_idx_e;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic               divide_fault;
  } out_t;

  // decoded calibration words, signedness applied at use
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } cal_t;

  // side data carried through the temperature divider
  typedef struct packed {
    logic signed [18:0] x1;
    logic [15:0]        up;
    logic               neg;
    logic               fault;
  } tdiv_side_t;

  // side data carried through the pressure divider
  typedef struct packed {
    logic signed [15:0] t;
    logic               fault;
    logic               dbl;
  } pdiv_side_t;

  localparam int D1_NW = 27;
  localparam int D1_DW = 20;
  localparam int D1_SW = $bits(tdiv_side_t);
  localparam int D2_NW = 32;
  localparam int D2_DW = 17;
  localparam int D2_SW = $bits(pdiv_side_t);

  localparam int FRONT_STAGES = 2;
  localparam int MID_STAGES   = 6;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY = FRONT_STAGES + D1_NW + MID_STAGES + D2_NW + BACK_STAGES;

  localparam logic signed [28:0] B6_OFFSET = 29'sd4000;
  localparam logic [31:0]        X3_BIAS   = 32'd32768;
  localparam logic [15:0]        B7_SCALE  = 16'd50000;
  localparam logic signed [13:0] P_SQ_K    = 14'sd3038;
  localparam logic signed [14:0] P_LIN_K   = -15'sd7357;
  localparam logic signed [47:0] P_OFFSET  = 48'sd3791;
  localparam logic signed [23:0] T_MAX     = 24'sd32767;
  localparam logic signed [23:0] T_MIN     = -24'sd32768;
  localparam logic signed [47:0] P_MAX     = 48'sd1048575;

endpackage

@@ hdl/baro_temp_pressure_compensation_top.sv @@
// Barometric temperature and pressure compensation, fully pipelined.
// A request (raw temperature and raw pressure word) is taken on any cycle
// with start high; busy never rises, so one request per cycle is sustained.
// Each result appears for a single cycle with result_valid_o high and
// cannot be held off. The pipeline is built from the two restoring
// dividers, one quotient bit per stage: 27 stages for the temperature
// divide and 32 for the pressure divide, plus 11 arithmetic stages.
// Calibration registers are written through cfg_we_i and take effect at
// once; write them only while no request is in flight.
`include "assert_macros.svh"

module baro_temp_pressure_compensation_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bptc_pkg::in_t                   in_i,
  input  logic                            cfg_we_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bptc_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                            result_valid_o,
  output bptc_pkg::out_t                  out_o
);

  bptc_pkg::cal_t               cal;
  logic                         accept;
  logic                         fv, d1v, mv, d2v;
  logic [bptc_pkg::D1_NW-1:0]   f_num, d1_quo;
  logic [bptc_pkg::D1_DW-1:0]   f_den;
  logic [bptc_pkg::D2_NW-1:0]   m_num, d2_quo;
  logic [bptc_pkg::D2_DW-1:0]   m_den;
  bptc_pkg::tdiv_side_t         f_side, d1_side;
  bptc_pkg::pdiv_side_t         m_side, d2_side;

  assign busy   = 1'b0;
  assign accept = start & ~busy & rst_ni;

  bptc_cal_regs u_cal (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cal_o (cal)
  );

  bptc_front u_front (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .in_i,
    .cal_i   (cal),
    .valid_o (fv),
    .num_o   (f_num),
    .den_o   (f_den),
    .side_o  (f_side)
  );

  bptc_div #(
    .NW(bptc_pkg::D1_NW), .DW(bptc_pkg::D1_DW), .SW(bptc_pkg::D1_SW)
  ) u_tdiv (
    .clk_i, .rst_ni,
    .valid_i (fv),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d1v),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  bptc_mid u_mid (
    .clk_i, .rst_ni,
    .valid_i (d1v),
    .quo_i   (d1_quo),
    .side_i  (d1_side),
    .cal_i   (cal),
    .valid_o (mv),
    .num_o   (m_num),
    .den_o   (m_den),
    .side_o  (m_side)
  );

  bptc_div #(
    .NW(bptc_pkg::D2_NW), .DW(bptc_pkg::D2_DW), .SW(bptc_pkg::D2_SW)
  ) u_pdiv (
    .clk_i, .rst_ni,
    .valid_i (mv),
    .num_i   (m_num),
    .den_i   (m_den),
    .side_i  (m_side),
    .valid_o (d2v),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  bptc_back u_back (
    .clk_i, .rst_ni,
    .valid_i (d2v),
    .quo_i   (d2_quo),
    .side_i  (d2_side),
    .valid_o (result_valid_o),
    .out_o
  );

  // every result traces back to an earlier accepted request
  `BPTC_ASSERT_IMPLY(a_result_latency, clk_i, rst_ni, result_valid_o, $past(accept, bptc_pkg::LATENCY), "result without matching request")
  // a faulted result carries zeros
  `BPTC_ASSERT_NEVER(a_fault_zero, clk_i, rst_ni, result_valid_o && out_o.divide_fault && (out_o.pressure_pa != 20'd0 || out_o.temperature_tenths != 16'sd0), "fault with nonzero result")

endmodule

@@ hdl/bptc_cal_regs.sv @@
// calibration register file with coefficient decode
module bptc_cal_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bptc_pkg::CFG_W-1:0]         cfg_data_i,
  output bptc_pkg::cal_t                     cal_o
);

  logic [bptc_pkg::CFG_W-1:0] r0_q, r1_q, r2_q, r3_q, r4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= '0;
      r1_q <= '0;
      r2_q <= '0;
      r3_q <= '0;
      r4_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bptc_pkg::CAL_AC1_AC2: r0_q <= cfg_data_i;
        bptc_pkg::CAL_AC3_AC4: r1_q <= cfg_data_i;
        bptc_pkg::CAL_AC5_AC6: r2_q <= cfg_data_i;
        bptc_pkg::CAL_B1_B2:   r3_q <= cfg_data_i;
        bptc_pkg::CAL_MC_MD:   r4_q <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_comb begin
    cal_o.ac1 = r0_q[31:16];
    cal_o.ac2 = r0_q[15:0];
    cal_o.ac3 = r1_q[31:16];
    cal_o.ac4 = r1_q[15:0];
    cal_o.ac5 = r2_q[31:16];
    cal_o.ac6 = r2_q[15:0];
    cal_o.b1  = r3_q[31:16];
    cal_o.b2  = r3_q[15:0];
    cal_o.mc  = r4_q[31:16];
    cal_o.md  = r4_q[15:0];
  end

endmodule

@@ hdl/bptc_div.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
module bptc_div #(
  parameter int NW = bptc_pkg::D2_NW,
  parameter int DW = bptc_pkg::D2_DW,
  parameter int SW = bptc_pkg::D2_SW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] acc_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] acc_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign acc_in  = acc_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // dividend bits shift out the top, quotient bits shift in the bottom
    assign trial = {rem_in, acc_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      acc_q[i]  <= {acc_in[NW-2:0], ge};
      den_q[i]  <= den_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = acc_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

@@ hdl/bptc_front.sv @@
// temperature front end: x1 and the operands of the temperature divide
module bptc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  bptc_pkg::in_t               in_i,
  input  bptc_pkg::cal_t              cal_i,
  output logic                        valid_o,
  output logic [bptc_pkg::D1_NW-1:0]  num_o,
  output logic [bptc_pkg::D1_DW-1:0]  den_o,
  output bptc_pkg::tdiv_side_t        side_o
);

  logic               v1_q, v2_q;
  logic signed [16:0] diff;
  logic signed [33:0] prod_d, prod_q;
  logic [15:0]        up1_q;
  logic signed [18:0] x1;
  logic signed [19:0] den;
  logic signed [26:0] num;
  logic [26:0]        num_mag_d, num_mag_q;
  logic [19:0]        den_mag_d, den_mag_q;
  bptc_pkg::tdiv_side_t side_d, side_q;

  assign diff   = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, cal_i.ac6});
  assign prod_d = diff * $signed({1'b0, cal_i.ac5});

  assign x1  = prod_q[33:15];
  assign den = $signed({x1[18], x1}) + $signed({{4{cal_i.md[15]}}, cal_i.md});
  assign num = $signed({cal_i.mc, 11'b0});

  always_comb begin
    num_mag_d = cal_i.mc[15] ? 27'(-num) : 27'(num);
    den_mag_d = den[19] ? 20'(-den) : 20'(den);
    side_d.x1    = x1;
    side_d.up    = up1_q;
    side_d.neg   = cal_i.mc[15] ^ den[19];
    side_d.fault = (den == 20'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    up1_q     <= in_i.raw_pressure;
    num_mag_q <= num_mag_d;
    den_mag_q <= den_mag_d;
    side_q    <= side_d;
  end

  assign valid_o = v2_q;
  assign num_o   = num_mag_q;
  assign den_o   = den_mag_q;
  assign side_o  = side_q;

endmodule

@@ hdl/bptc_mid.sv @@
// temperature result, b3, b4 and b7, operands of the pressure divide
module bptc_mid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [bptc_pkg::D1_NW-1:0]  quo_i,
  input  bptc_pkg::tdiv_side_t        side_i,
  input  bptc_pkg::cal_t              cal_i,
  output logic                        valid_o,
  output logic [bptc_pkg::D2_NW-1:0]  num_o,
  output logic [bptc_pkg::D2_DW-1:0]  den_o,
  output bptc_pkg::pdiv_side_t        side_o
);

  logic [5:0] v_q;

  // stage 1: b5, t, b6
  logic signed [27:0] q28, x2, b5, bsum;
  logic signed [23:0] tr;
  logic signed [15:0] t_d, t1_q, t2_q, t3_q, t4_q, t5_q;
  logic signed [28:0] b6_d, b6_q;
  logic [15:0]        up1_q, up2_q, up3_q, up4_q;
  logic               f1_q, f2_q, f3_q, f4_q, f5_q;

  assign q28  = $signed({1'b0, quo_i});
  assign x2   = side_i.neg ? -q28 : q28;
  assign b5   = $signed({{9{side_i.x1[18]}}, side_i.x1}) + x2;
  assign bsum = b5 + 28'sd8;
  assign tr   = bsum[27:4];
  assign b6_d = $signed({b5[27], b5}) - bptc_pkg::B6_OFFSET;

  always_comb begin
    if (tr > bptc_pkg::T_MAX) begin
      t_d = 16'sh7fff;
    end else if (tr < bptc_pkg::T_MIN) begin
      t_d = -16'sh8000;
    end else begin
      t_d = tr[15:0];
    end
  end

  // stage 2: b6 squared and the linear products
  logic signed [57:0] sq_d, sq_q;
  logic signed [44:0] ac2b6_d, ac2b6_q, ac2b6_3q;
  logic signed [44:0] ac3b6_d, ac3b6_q, ac3b6_3q;

  assign sq_d    = b6_q * b6_q;
  assign ac2b6_d = $signed(cal_i.ac2) * b6_q;
  assign ac3b6_d = $signed(cal_i.ac3) * b6_q;

  // stage 3: b6sq times b2 and b1
  logic signed [46:0] b6sq;
  logic signed [62:0] pb2_d, pb2_q, pb1_d, pb1_q;

  assign b6sq  = $signed({1'b0, sq_q[57:12]});
  assign pb2_d = $signed(cal_i.b2) * b6sq;
  assign pb1_d = $signed(cal_i.b1) * b6sq;

  // stage 4: b3 and the b4 factor, only the low words are needed
  logic signed [53:0] sum_a;
  logic signed [48:0] sum_b;
  logic [31:0]        b3lo_d, b3lo_q, xb_d, xb_q;

  assign sum_a = $signed({{36{cal_i.ac1[15]}}, cal_i.ac1, 2'b00})
               + $signed({{2{pb2_q[62]}}, pb2_q[62:11]})
               + $signed({{20{ac2b6_3q[44]}}, ac2b6_3q[44:11]})
               + 54'sd2;
  assign sum_b = $signed({{17{ac3b6_3q[44]}}, ac3b6_3q[44:13]})
               + $signed({{2{pb1_q[62]}}, pb1_q[62:16]})
               + 49'sd2;
  assign b3lo_d = sum_a[33:2];
  assign xb_d   = sum_b[33:2] + bptc_pkg::X3_BIAS;

  // stage 5: b4 and b7, both wrap to 32 bits
  logic [47:0] b4p, b7p;
  logic [31:0] dif;
  logic [16:0] b4_d, b4_q;
  logic [31:0] b7_q;

  assign b4p  = cal_i.ac4 * xb_q;
  assign b4_d = b4p[31:15];
  assign dif  = {16'b0, up4_q} - b3lo_q;
  assign b7p  = dif * bptc_pkg::B7_SCALE;

  // stage 6: dividend select and fault
  logic [31:0]          n_d, n_q;
  logic [16:0]          d_q;
  bptc_pkg::pdiv_side_t s_d, s_q;

  assign n_d = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
  always_comb begin
    s_d.t     = t5_q;
    s_d.fault = f5_q | (b4_q == 17'd0);
    s_d.dbl   = b7_q[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q     <= t_d;
    b6_q     <= b6_d;
    up1_q    <= side_i.up;
    f1_q     <= side_i.fault;
    sq_q     <= sq_d;
    ac2b6_q  <= ac2b6_d;
    ac3b6_q  <= ac3b6_d;
    t2_q     <= t1_q;
    up2_q    <= up1_q;
    f2_q     <= f1_q;
    pb2_q    <= pb2_d;
    pb1_q    <= pb1_d;
    ac2b6_3q <= ac2b6_q;
    ac3b6_3q <= ac3b6_q;
    t3_q     <= t2_q;
    up3_q    <= up2_q;
    f3_q     <= f2_q;
    b3lo_q   <= b3lo_d;
    xb_q     <= xb_d;
    t4_q     <= t3_q;
    up4_q    <= up3_q;
    f4_q     <= f3_q;
    b4_q     <= b4_d;
    b7_q     <= b7p[31:0];
    t5_q     <= t4_q;
    f5_q     <= f4_q;
    n_q      <= n_d;
    d_q      <= b4_q;
    s_q      <= s_d;
  end

  assign valid_o = v_q[5];
  assign num_o   = n_q;
  assign den_o   = d_q;
  assign side_o  = s_q;

endmodule

@@ hdl/bptc_back.sv @@
// pressure correction polynomial, saturation and result register
module bptc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [bptc_pkg::D2_NW-1:0]  quo_i,
  input  bptc_pkg::pdiv_side_t        side_i,
  output logic                        valid_o,
  output bptc_pkg::out_t              out_o
);

  logic [2:0] v_q;

  // stage 1: p, its square and the linear term
  logic [31:0]        pu;
  logic signed [23:0] ps;
  logic signed [47:0] sq2_d, sq2_q;
  logic signed [46:0] m2_d, m2_q;
  logic signed [31:0] p1_q, p2_q;
  logic signed [15:0] t1_q, t2_q;
  logic               f1_q, f2_q;

  assign pu    = side_i.dbl ? {quo_i[30:0], 1'b0} : quo_i;
  assign ps    = pu[31:8];
  assign sq2_d = ps * ps;
  assign m2_d  = $signed(pu) * bptc_pkg::P_LIN_K;

  // stage 2: scale the square
  logic signed [61:0] prod_d, prod_q;
  logic signed [30:0] x2_q;

  assign prod_d = sq2_q * bptc_pkg::P_SQ_K;

  // stage 3: final sum and clamp
  logic signed [47:0] s, pn;
  bptc_pkg::out_t     o_d, o_q;

  assign s  = $signed({{2{prod_q[61]}}, prod_q[61:16]})
            + $signed({{17{x2_q[30]}}, x2_q})
            + bptc_pkg::P_OFFSET;
  assign pn = $signed({{16{p2_q[31]}}, p2_q}) + $signed({{4{s[47]}}, s[47:4]});

  always_comb begin
    o_d.divide_fault = f2_q;
    if (f2_q) begin
      o_d.temperature_tenths = '0;
      o_d.pressure_pa        = '0;
    end else begin
      o_d.temperature_tenths = t2_q;
      if (pn < 48'sd0) begin
        o_d.pressure_pa = '0;
      end else if (pn > bptc_pkg::P_MAX) begin
        o_d.pressure_pa = '1;
      end else begin
        o_d.pressure_pa = pn[19:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sq2_q  <= sq2_d;
    m2_q   <= m2_d;
    p1_q   <= $signed(pu);
    t1_q   <= side_i.t;
    f1_q   <= side_i.fault;
    prod_q <= prod_d;
    x2_q   <= m2_q[46:16];
    p2_q   <= p1_q;
    t2_q   <= t1_q;
    f2_q   <= f1_q;
    o_q    <= o_d;
  end

  assign valid_o = v_q[2];
  assign out_o   = o_q;

endmodule

@@ tb/tb_baro_temp_pressure_compensation_top.sv @@
// testbench for the barometric temperature and pressure compensation pipeline
`timescale 1ns / 100ps

module tb_baro_temp_pressure_compensation_top;

  localparam logic [bptc_pkg::CFG_IDX_W-1:0] CAL_IDX_SPARE_LO = 3'd5;
  localparam logic [bptc_pkg::CFG_IDX_W-1:0] CAL_IDX_SPARE_HI = 3'd7;
  localparam int                             NUM_CAL          = 5;
  localparam int                             RANDOM_PHASES    = 12;
  localparam int                             REQS_PER_PHASE   = 104;

  typedef struct {
    bit                             wr;
    logic [bptc_pkg::CFG_IDX_W-1:0] idx;
    logic [bptc_pkg::CFG_W-1:0]     data;
    bptc_pkg::in_t                  req;
    bit                             typed;
    bptc_pkg::out_t                 want;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  bptc_pkg::in_t                  in_i;
  logic                           cfg_we_i;
  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bptc_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           result_valid_o;
  bptc_pkg::out_t                 out_o;

  logic [bptc_pkg::CFG_W-1:0] cal_regs [NUM_CAL];
  bptc_pkg::out_t             expected_readings [$];
  stim_row_t                  stim_table [$];
  int                         errors;

  baro_temp_pressure_compensation_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .out_o         (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // fixed-point compensation, arithmetic shifts are floor shifts on signed 64-bit values
  function automatic bptc_pkg::out_t compensate_reading(bptc_pkg::in_t req);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, den, b5, t, b6, b6sq, b3, p, x3b;
    logic [31:0] prod, b4, b7, pu, up;
    bptc_pkg::out_t r;
    r = '0;
    r.divide_fault = 1'b1;
    ac1 = longint'($signed(cal_regs[bptc_pkg::CAL_AC1_AC2][31:16]));
    ac2 = longint'($signed(cal_regs[bptc_pkg::CAL_AC1_AC2][15:0]));
    ac3 = longint'($signed(cal_regs[bptc_pkg::CAL_AC3_AC4][31:16]));
    ac4 = longint'(cal_regs[bptc_pkg::CAL_AC3_AC4][15:0]);
    ac5 = longint'(cal_regs[bptc_pkg::CAL_AC5_AC6][31:16]);
    ac6 = longint'(cal_regs[bptc_pkg::CAL_AC5_AC6][15:0]);
    b1  = longint'($signed(cal_regs[bptc_pkg::CAL_B1_B2][31:16]));
    b2  = longint'($signed(cal_regs[bptc_pkg::CAL_B1_B2][15:0]));
    mc  = longint'($signed(cal_regs[bptc_pkg::CAL_MC_MD][31:16]));
    md  = longint'($signed(cal_regs[bptc_pkg::CAL_MC_MD][15:0]));
    ut  = longint'(req.raw_temperature);
    up  = {16'd0, req.raw_pressure};

    x1 = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = (b5 + 8) >>> 4;

    b6 = b5 - 4000;
    b6sq = (b6 * b6) >>> 12;
    x1 = (b2 * b6sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    b3 = (ac1 * 4 + x1 + x2 + 2) >>> 2;

    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * b6sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    x3b = x3 + 32768;
    prod = ac4[31:0] * x3b[31:0];
    b4 = prod >> 15;
    if (b4 == 32'd0) return r;

    // b4 and b7 wrap at 32 bits
    b7 = (up - b3[31:0]) * 32'd50000;
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else pu = (b7 / b4) * 32'd2;
    p = longint'($signed(pu));

    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * 3038) >>> 16;
    x2 = (-7357 * p) >>> 16;
    p = p + ((x1 + x2 + 3791) >>> 4);

    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p < 0) p = 0;
    if (p > 1048575) p = 1048575;
    r.temperature_tenths = t[15:0];
    r.pressure_pa = p[19:0];
    r.divide_fault = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    bptc_pkg::out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: temp %0d pa %0d fault %0b",
               out_o.temperature_tenths, out_o.pressure_pa, out_o.divide_fault);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (out_o.temperature_tenths !== want.temperature_tenths) begin
          $error("temperature_tenths: expected %0d, got %0d",
                 want.temperature_tenths, out_o.temperature_tenths);
          errors++;
        end
        if (out_o.pressure_pa !== want.pressure_pa) begin
          $error("pressure_pa: expected %0d, got %0d", want.pressure_pa, out_o.pressure_pa);
          errors++;
        end
        if (out_o.divide_fault !== want.divide_fault) begin
          $error("divide_fault: expected %0b, got %0b", want.divide_fault, out_o.divide_fault);
          errors++;
        end
      end
    end
  end

  // issue one request, then leave the line idle for the given gap
  task automatic issue_reading(bptc_pkg::in_t req, int gap, bit typed, bptc_pkg::out_t want);
    bptc_pkg::out_t pred;
    start <= 1'b1;
    in_i  <= req;
    do @(posedge clk_i); while (busy);
    pred = compensate_reading(req);
    if (typed && pred !== want) begin
      $error("typed row disagrees: expected %h, predicted %h", want, pred);
      errors++;
    end
    expected_readings.push_back(typed ? want : pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cal(logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bptc_pkg::CFG_W-1:0] data);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < NUM_CAL) cal_regs[idx] = data;
    @(posedge clk_i);
  endtask

  task automatic add_write(logic [bptc_pkg::CFG_IDX_W-1:0] idx,
                           logic [bptc_pkg::CFG_W-1:0] data);
    stim_row_t row;
    row = '{wr: 1'b1, idx: idx, data: data, req: '0, typed: 1'b0, want: '0};
    stim_table.push_back(row);
  endtask

  task automatic add_req(logic [15:0] ut, logic [15:0] up, bit typed, bptc_pkg::out_t want);
    stim_row_t row;
    row = '{wr: 1'b0, idx: '0, data: '0, req: '{ut, up}, typed: typed, want: want};
    stim_table.push_back(row);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic load_standard_cal(bit perturb);
    logic [31:0] mask;
    mask = perturb ? 32'h00FF_00FF & $urandom() : 32'd0;
    write_cal(bptc_pkg::CAL_AC1_AC2, {16'sd408, -16'sd72} ^ mask);
    write_cal(bptc_pkg::CAL_AC3_AC4, {-16'sd14383, 16'd32741} ^ (mask >> 1));
    write_cal(bptc_pkg::CAL_AC5_AC6, {16'd32757, 16'd23153} ^ (mask >> 2));
    write_cal(bptc_pkg::CAL_B1_B2, {16'sd6190, 16'sd4} ^ (mask >> 3));
    write_cal(bptc_pkg::CAL_MC_MD, {-16'sd8711, 16'sd2868} ^ (mask >> 4));
  endtask

  initial begin
    bptc_pkg::out_t fault_res;
    stim_row_t row;
    bit burst;
    int gap;
    logic [15:0] ut;

    errors     = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    in_i       = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    for (int i = 0; i < NUM_CAL; i++) cal_regs[i] = '0;
    fault_res = '{temperature_tenths: 16'sd0, pressure_pa: 20'd0, divide_fault: 1'b1};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calibration all zero after reset: temperature divisor is zero
    add_req(16'h0000, 16'h0000, 1'b1, fault_res);
    add_req(16'hFFFF, 16'hFFFF, 1'b1, fault_res);
    // nonzero divisor but AC4 zero: pressure divisor is zero
    add_write(bptc_pkg::CAL_MC_MD, {16'd0, 16'd1});
    add_req(16'h1234, 16'h8001, 1'b1, fault_res);
    // writes to spare indexes change nothing
    add_write(CAL_IDX_SPARE_HI, 32'hFFFF_FFFF);
    add_write(CAL_IDX_SPARE_LO, 32'hFFFF_FFFF);
    add_req(16'hFFFF, 16'h0000, 1'b1, fault_res);
    // typical calibration
    add_write(bptc_pkg::CAL_AC1_AC2, {16'sd408, -16'sd72});
    add_write(bptc_pkg::CAL_AC3_AC4, {-16'sd14383, 16'd32741});
    add_write(bptc_pkg::CAL_AC5_AC6, {16'd32757, 16'd23153});
    add_write(bptc_pkg::CAL_B1_B2, {16'sd6190, 16'sd4});
    add_write(bptc_pkg::CAL_MC_MD, {-16'sd8711, 16'sd2868});
    add_req(16'd27898, 16'd23843, 1'b0, fault_res);
    add_req(16'h0000, 16'h0000, 1'b0, fault_res);
    add_req(16'hFFFF, 16'hFFFF, 1'b0, fault_res);
    add_req(16'h0000, 16'hFFFF, 1'b0, fault_res);
    add_req(16'hFFFF, 16'h0000, 1'b0, fault_res);
    add_req(16'h5555, 16'hAAAA, 1'b0, fault_res);
    add_req(16'hAAAA, 16'h5555, 1'b0, fault_res);
    // ut equal to AC6 gives x1 of zero; MD zero makes the divisor zero
    add_write(bptc_pkg::CAL_MC_MD, {-16'sd8711, 16'sd0});
    add_req(16'd23153, 16'd30000, 1'b1, fault_res);
    add_req(16'd27898, 16'd23843, 1'b0, fault_res);
    // huge MC over a unit divisor drives temperature to both rails
    add_write(bptc_pkg::CAL_MC_MD, {16'h7FFF, 16'sd1});
    add_req(16'd23153, 16'd40000, 1'b0, fault_res);
    add_req(16'd23153, 16'hFFFF, 1'b0, fault_res);
    add_write(bptc_pkg::CAL_MC_MD, {16'h8000, 16'sd1});
    add_req(16'd23153, 16'd40000, 1'b0, fault_res);
    add_req(16'd23153, 16'h0000, 1'b0, fault_res);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.wr) write_cal(row.idx, row.data);
      else issue_reading(row.req, $urandom_range(0, 15), row.typed, row.want);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: for (int r = 0; r < NUM_CAL; r++) write_cal(3'(r), 32'hFFFF_FFFF);
        1: for (int r = 0; r < NUM_CAL; r++) write_cal(3'(r), 32'h8000_8000);
        2: for (int r = 0; r < NUM_CAL; r++) write_cal(3'(r), 32'h7FFF_7FFF);
        3, 4, 5: for (int r = 0; r < NUM_CAL; r++) write_cal(3'(r), $urandom());
        default: load_standard_cal(ph != 6);
      endcase
      if ($urandom_range(0, 1)) write_cal(3'($urandom_range(5, 7)), $urandom());
      burst = (ph % 3 == 1);
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        // near the calibrated AC6 most temperature words stay realistic
        if (ph >= 6 && $urandom_range(0, 3) != 0) ut = 16'($urandom_range(20000, 32000));
        else ut = rand_word();
        gap = burst ? 0 : $urandom_range(0, 15);
        issue_reading('{ut, rand_word()}, gap, 1'b0, fault_res);
      end
    end

    drain();
    repeat (bptc_pkg::LATENCY + 10) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $error("%0d results never arrived", expected_readings.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
